### rtl/gmt_pkg.sv
`default_nettype none

package gmt_pkg;

  // Table geometry
  localparam int TABLE_SLOTS = 16;
  localparam int IDX_W       = (TABLE_SLOTS > 1) ? $clog2(TABLE_SLOTS) : 1;
  localparam int CNT_W       = $clog2(TABLE_SLOTS + 1);
  localparam int GROUP_W     = 16;
  localparam int EP_W        = 8;

  // Command codes
  localparam logic [1:0] CMD_ADD        = 2'd0;
  localparam logic [1:0] CMD_REMOVE     = 2'd1;
  localparam logic [1:0] CMD_REMOVE_ALL = 2'd2;
  localparam logic [1:0] CMD_QUERY      = 2'd3;

  // Status codes
  localparam logic [1:0] STS_SUCCESS = 2'd0;
  localparam logic [1:0] STS_FULL    = 2'd1;
  localparam logic [1:0] STS_INVALID = 2'd2;

  // Requests from the sequencer to the slot store
  typedef struct packed {
    logic               rd_en;
    logic [IDX_W-1:0]   rd_addr;
    logic               wr_en;
    logic [IDX_W-1:0]   wr_addr;
    logic [GROUP_W-1:0] wr_group;
    logic [EP_W-1:0]    wr_endpoint;
    logic               clr_one;
    logic [IDX_W-1:0]   clr_addr;
    logic               clr_all;
  } gmt_mem_req_t;

  // Registered read data from the slot store
  typedef struct packed {
    logic               valid;
    logic [GROUP_W-1:0] group;
    logic [EP_W-1:0]    endpoint;
  } gmt_mem_rsp_t;

  // Finished result of one item
  typedef struct packed {
    logic [1:0] status;
    logic       group_found;
  } gmt_result_t;

endpackage

`default_nettype wire

### rtl/gmt_store.sv
`default_nettype none

module gmt_store (
  input  wire                   clk,
  input  wire                   rst_n,
  input  gmt_pkg::gmt_mem_req_t req,
  output gmt_pkg::gmt_mem_rsp_t rsp
);
  import gmt_pkg::*;

  logic [GROUP_W+EP_W-1:0] slot_mem [TABLE_SLOTS];
  logic [TABLE_SLOTS-1:0]  slot_valid_r;
  logic [TABLE_SLOTS-1:0]  slot_valid_nxt;
  gmt_mem_rsp_t            rsp_r;

  // Write group and endpoint of a slot; read data is registered
  always_ff @(posedge clk) begin
    if (req.wr_en) begin
      slot_mem[req.wr_addr] <= {req.wr_group, req.wr_endpoint};
    end
    if (req.rd_en) begin
      {rsp_r.group, rsp_r.endpoint} <= slot_mem[req.rd_addr];
      rsp_r.valid                   <= slot_valid_r[req.rd_addr];
    end
  end

  // Update valid flags: clear all wins, then set on fill, clear on remove
  always_comb begin
    slot_valid_nxt = slot_valid_r;
    if (req.clr_all) begin
      slot_valid_nxt = '0;
    end else begin
      if (req.wr_en) begin
        slot_valid_nxt[req.wr_addr] = 1'b1;
      end
      if (req.clr_one) begin
        slot_valid_nxt[req.clr_addr] = 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      slot_valid_r <= '0;
    end else begin
      slot_valid_r <= slot_valid_nxt;
    end
  end

  assign rsp = rsp_r;

endmodule

`default_nettype wire

### rtl/gmt_ctrl.sv
`default_nettype none

module gmt_ctrl (
  input  wire                          clk,
  input  wire                          rst_n,
  input  wire                          in_valid,
  output logic                         in_stall,
  input  wire  [1:0]                   in_cmd,
  input  wire  [gmt_pkg::GROUP_W-1:0]  in_group_id,
  input  wire  [gmt_pkg::EP_W-1:0]     in_endpoint,
  output gmt_pkg::gmt_mem_req_t        mem_req,
  input  gmt_pkg::gmt_mem_rsp_t        mem_rsp,
  output logic                         res_valid,
  output gmt_pkg::gmt_result_t         res,
  input  wire                          res_taken
);
  import gmt_pkg::*;

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_SCAN = 2'd1;
  localparam logic [1:0] S_FIN  = 2'd2;

  logic [1:0]         state_r,     state_nxt;
  logic [CNT_W-1:0]   cnt_r,       cnt_nxt;
  logic               rd_pend_r,   rd_pend_nxt;
  logic [IDX_W-1:0]   rd_idx_r,    rd_idx_nxt;
  logic               match_r,     match_nxt;
  logic [IDX_W-1:0]   match_idx_r, match_idx_nxt;
  logic               free_r,      free_nxt;
  logic [IDX_W-1:0]   free_idx_r,  free_idx_nxt;
  logic               gfound_r,    gfound_nxt;
  logic [1:0]         cmd_r,       cmd_nxt;
  logic [GROUP_W-1:0] gid_r,       gid_nxt;
  logic [EP_W-1:0]    ep_r,        ep_nxt;

  logic accept;
  logic grp_hit;
  logic pair_hit;

  assign in_stall = (state_r != S_IDLE);
  assign accept   = in_valid && !in_stall;
  assign grp_hit  = mem_rsp.valid && (mem_rsp.group == gid_r);
  assign pair_hit = grp_hit && (mem_rsp.endpoint == ep_r);

  // Sequence: latch item, scan every slot (remove all skips the scan), then commit and hand over the result
  always_comb begin
    state_nxt     = state_r;
    cnt_nxt       = cnt_r;
    rd_pend_nxt   = 1'b0;
    rd_idx_nxt    = rd_idx_r;
    match_nxt     = match_r;
    match_idx_nxt = match_idx_r;
    free_nxt      = free_r;
    free_idx_nxt  = free_idx_r;
    gfound_nxt    = gfound_r;
    cmd_nxt       = cmd_r;
    gid_nxt       = gid_r;
    ep_nxt        = ep_r;
    mem_req       = '0;
    res_valid     = 1'b0;
    res           = '0;

    unique case (state_r)
      S_IDLE: begin
        if (accept) begin
          cmd_nxt    = in_cmd;
          gid_nxt    = in_group_id;
          ep_nxt     = in_endpoint;
          cnt_nxt    = '0;
          match_nxt  = 1'b0;
          free_nxt   = 1'b0;
          gfound_nxt = 1'b0;
          state_nxt  = (in_cmd == CMD_REMOVE_ALL) ? S_FIN : S_SCAN;
        end
      end

      S_SCAN: begin
        // Issue the next slot read
        if (cnt_r < CNT_W'(TABLE_SLOTS)) begin
          mem_req.rd_en   = 1'b1;
          mem_req.rd_addr = cnt_r[IDX_W-1:0];
          rd_pend_nxt     = 1'b1;
          rd_idx_nxt      = cnt_r[IDX_W-1:0];
          cnt_nxt         = cnt_r + 1'b1;
        end else if (!rd_pend_r) begin
          state_nxt = S_FIN;
        end
        // Check the slot read in the previous cycle; keep the lowest hits
        if (rd_pend_r) begin
          if (pair_hit && !match_r) begin
            match_nxt     = 1'b1;
            match_idx_nxt = rd_idx_r;
          end
          if (!mem_rsp.valid && !free_r) begin
            free_nxt     = 1'b1;
            free_idx_nxt = rd_idx_r;
          end
          if (grp_hit) begin
            gfound_nxt = 1'b1;
          end
        end
      end

      S_FIN: begin
        res_valid = 1'b1;
        unique case (cmd_r)
          CMD_ADD: begin
            if (match_r) begin
              res.status = STS_SUCCESS;
            end else if (free_r) begin
              res.status          = STS_SUCCESS;
              mem_req.wr_en       = res_taken;
              mem_req.wr_addr     = free_idx_r;
              mem_req.wr_group    = gid_r;
              mem_req.wr_endpoint = ep_r;
            end else begin
              res.status = STS_FULL;
            end
          end
          CMD_REMOVE: begin
            if (match_r) begin
              res.status       = STS_SUCCESS;
              mem_req.clr_one  = res_taken;
              mem_req.clr_addr = match_idx_r;
            end else begin
              res.status = STS_INVALID;
            end
          end
          CMD_REMOVE_ALL: begin
            res.status      = STS_SUCCESS;
            mem_req.clr_all = res_taken;
          end
          CMD_QUERY: begin
            res.status      = STS_SUCCESS;
            res.group_found = gfound_r;
          end
          default: begin
            res.status = STS_SUCCESS;
          end
        endcase
        if (res_taken) begin
          state_nxt = S_IDLE;
        end
      end

      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= S_IDLE;
      rd_pend_r <= 1'b0;
    end else begin
      state_r   <= state_nxt;
      rd_pend_r <= rd_pend_nxt;
    end
  end

  // Hold item and scan results
  always_ff @(posedge clk) begin
    cnt_r       <= cnt_nxt;
    rd_idx_r    <= rd_idx_nxt;
    match_r     <= match_nxt;
    match_idx_r <= match_idx_nxt;
    free_r      <= free_nxt;
    free_idx_r  <= free_idx_nxt;
    gfound_r    <= gfound_nxt;
    cmd_r       <= cmd_nxt;
    gid_r       <= gid_nxt;
    ep_r        <= ep_nxt;
  end

endmodule

`default_nettype wire

### rtl/group_membership_table_core.sv
`default_nettype none

// Channel  Direction  Handshake          Payload
// in_      input      in_valid/in_stall  in_cmd, in_group_id, in_endpoint
// out_     output     out_valid/out_stall out_status, out_group_found
//
// Add, remove and query scan every slot before the result is loaded into the
// output register; remove all skips the scan. The scan reads one slot a cycle
// through the single read port of the slot memory. A new item is taken once
// the previous one has been committed, while its result may still wait in
// the output register. Reset clears the valid flags of all slots at once. A
// stalled output holds the sequencer in its commit step until the output
// register frees up.

module group_membership_table_core (
  input  wire         clk,
  input  wire         rst_n,
  input  wire         in_valid,
  output logic        in_stall,
  input  wire  [1:0]  in_cmd,
  input  wire  [15:0] in_group_id,
  input  wire  [7:0]  in_endpoint,
  output logic        out_valid,
  input  wire         out_stall,
  output logic [1:0]  out_status,
  output logic        out_group_found
);
  import gmt_pkg::*;

  gmt_mem_req_t mem_req;
  gmt_mem_rsp_t mem_rsp;
  gmt_result_t  res;
  logic         res_valid;
  logic         res_taken;
  logic         out_valid_r;
  gmt_result_t  out_r;

  gmt_store u_store (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (mem_req),
    .rsp   (mem_rsp)
  );

  gmt_ctrl u_ctrl (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (in_valid),
    .in_stall    (in_stall),
    .in_cmd      (in_cmd),
    .in_group_id (in_group_id),
    .in_endpoint (in_endpoint),
    .mem_req     (mem_req),
    .mem_rsp     (mem_rsp),
    .res_valid   (res_valid),
    .res         (res),
    .res_taken   (res_taken)
  );

  // Load the output register when it is empty or being drained
  assign res_taken = res_valid && (!out_valid_r || !out_stall);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (res_taken) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (res_taken) begin
      out_r <= res;
    end
  end

  assign out_valid       = out_valid_r;
  assign out_status      = out_r.status;
  assign out_group_found = out_r.group_found;

  // Sequencer is busy in the cycle after an item is taken
  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && !in_stall) |=> in_stall)
    else $error("input not stalled after an item was taken");

  // Only a query reports a found group, and always with success
  a_found_success: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_group_found) |-> (out_status == STS_SUCCESS))
    else $error("group found reported with a failing status");

  // No undefined status code leaves the block
  a_status_code: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_status == STS_SUCCESS || out_status == STS_FULL ||
                   out_status == STS_INVALID))
    else $error("undefined status code on output");

  // A stalled result is never overwritten by the sequencer
  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_stall) |=> (out_valid && $stable(out_status) &&
                                  $stable(out_group_found)))
    else $error("stalled result changed");

endmodule

`default_nettype wire
